[design/gobu_pkg.sv]
// ---------------------------------------------------------------------------
// gobu_pkg: shared constants and helpers for the obstacle boundary block
// Grid geometry, request codes, register indexes and the Q16.16 helpers.
// ---------------------------------------------------------------------------
package gobu_pkg;

    localparam int GRID_W    = 64;
    localparam int GRID_H    = 64;
    localparam int COL_W     = $clog2(GRID_W);
    localparam int ROW_W     = $clog2(GRID_H);
    localparam int ADDR_W    = COL_W + ROW_W;
    localparam int DEPTH     = GRID_W * GRID_H;
    localparam int CRD_W     = 7;
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_APPLY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_END_A_COL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_A_ROW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_B_COL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_B_ROW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THICKNESS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BORDER_MODE = 3'd5;

    localparam logic [1:0] MODE_NEG_X = 2'd1;
    localparam logic [1:0] MODE_NEG_Y = 2'd2;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    function automatic logic signed [DATA_W-1:0] sat_neg(input logic signed [DATA_W-1:0] v);
        logic signed [DATA_W-1:0] res;
        if (v == {1'b1, {(DATA_W-1){1'b0}}}) begin
            res = {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            res = -v;
        end
        return res;
    endfunction

    function automatic logic signed [DATA_W-1:0] half_sum(input logic signed [DATA_W-1:0] a,
                                                          input logic signed [DATA_W-1:0] b);
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        return s[DATA_W:1];
    endfunction

endpackage

[design/grid_obstacle_boundary_update.sv]
// ---------------------------------------------------------------------------
// grid_obstacle_boundary_update: Q16.16 grid with an obstacle boundary pass
// Cell store with write and read requests and a sequenced boundary pass.
// ---------------------------------------------------------------------------
// A write request leaves the block idle and ready again in the next cycle.
// A read passes through the registered memory read and S_READ, then its
// result waits at the output until taken. An apply request walks the
// obstacle through the single memory port pair: a mirrored cell is a read,
// then a write (S_RD, S_WR), a cleared cell one S_ZERO step and a corner
// S_RD, S_RD2 and S_WR, so a pass lengthens with the segment length L and
// the thickness T, bounded by the memory port. A rejected geometry answers
// in the next cycle with status 1 and leaves the grid untouched. The grid has
// no reset: a cell must be written before it is read. Configuration may be
// written only while the block is idle.
module grid_obstacle_boundary_update
    import gobu_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_op,
    input  logic [5:0]               i_col,
    input  logic [5:0]               i_row,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_read_value,
    output logic                     o_status
);

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_RD, S_RD2, S_WR, S_ZERO, S_OUT
    } t_state;

    // Step of the pass; u runs along the segment, v across it.
    typedef enum logic [2:0] {
        PH_TOP, PH_BOT, PH_SA, PH_SB, PH_C0, PH_C1, PH_C2, PH_C3
    } t_phase;

    t_state  r_state;
    t_phase  r_phase;

    logic [5:0] r_a_col, r_a_row, r_b_col, r_b_row, r_thick;
    logic [1:0] r_mode;

    logic [CRD_W-1:0] r_u, r_v, r_ua, r_ub, r_vb, r_vt;
    logic             r_xdir, r_neg_across, r_neg_along;

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] r_rdata, r_first;
    logic                     r_rd_off;

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // Geometry check and endpoint ordering, evaluated when a request is taken.
    logic       g_span, g_line, g_xdir, g_swap, g_ok;
    logic [5:0] g_ua, g_ub, g_vb;
    logic [CRD_W-1:0] g_vt;

    always_comb begin
        g_span = (r_a_col >= 6'd2) && (r_a_col <= 6'(GRID_W - 2)) &&
                 (r_b_col >= 6'd2) && (r_b_col <= 6'(GRID_W - 2)) &&
                 (r_a_row >= 6'd2) && (r_a_row <= 6'(GRID_H - 2)) &&
                 (r_b_row >= 6'd2) && (r_b_row <= 6'(GRID_H - 2));
        g_line = (r_a_col == r_b_col) || (r_a_row == r_b_row);
        g_xdir = (r_a_row == r_b_row);
        g_swap = g_xdir ? (r_a_col > r_b_col) : (r_a_row > r_b_row);
        if (g_xdir) begin
            g_ua = g_swap ? r_b_col : r_a_col;
            g_ub = g_swap ? r_a_col : r_b_col;
            g_vb = r_a_row;
        end else begin
            g_ua = g_swap ? r_b_row : r_a_row;
            g_ub = g_swap ? r_a_row : r_b_row;
            g_vb = r_a_col;
        end
        g_vt = {1'b0, g_vb} + {1'b0, r_thick};
        g_ok = g_span && g_line &&
               (g_vt < (g_xdir ? CRD_W'(GRID_H - 2) : CRD_W'(GRID_W - 2)));
    end

    // Address selection for the current step, in (u, v) terms.
    logic [CRD_W-1:0] w_u, w_v, w_col, w_row;
    logic             w_off, w_we;
    logic signed [DATA_W-1:0] w_cur, w_wdata;

    always_comb begin
        w_u = r_u;
        w_v = r_v;
        case (r_phase)
            PH_TOP: begin
                w_v = (r_state == S_WR) ? r_vt + 7'd1 : r_vt + 7'd2;
            end
            PH_BOT: begin
                w_v = (r_state == S_WR) ? r_vb - 7'd1 : r_vb - 7'd2;
            end
            PH_SA: begin
                w_u = (r_state == S_WR) ? r_ua - 7'd1 : r_ua - 7'd2;
            end
            PH_SB: begin
                w_u = (r_state == S_WR) ? r_ub + 7'd1 : r_ub + 7'd2;
            end
            PH_C0, PH_C1, PH_C2, PH_C3: begin
                if (r_phase == PH_C0 || r_phase == PH_C1) begin
                    w_u = (r_state == S_RD2) ? r_ua : r_ua - 7'd1;
                end else begin
                    w_u = (r_state == S_RD2) ? r_ub : r_ub + 7'd1;
                end
                if (r_phase == PH_C0 || r_phase == PH_C2) begin
                    w_v = (r_state == S_RD) ? r_vt : r_vt + 7'd1;
                end else begin
                    w_v = (r_state == S_RD) ? r_vb : r_vb - 7'd1;
                end
            end
            default: begin
                w_u = r_u;
            end
        endcase
        if (r_state == S_ZERO) begin
            w_u = r_u;
            w_v = r_v;
        end
        if (r_state == S_IDLE) begin
            w_col = {1'b0, i_col};
            w_row = {1'b0, i_row};
        end else begin
            w_col = r_xdir ? w_u : w_v;
            w_row = r_xdir ? w_v : w_u;
        end
        w_off = w_col[CRD_W-1] || w_row[CRD_W-1];
    end

    // The shared datapath: negate, pass or average the value just read, or write zero or the request value.
    always_comb begin
        w_cur = r_rd_off ? '0 : r_rdata;
        if (r_state == S_ZERO) begin
            w_wdata = '0;
        end else if (r_state == S_IDLE) begin
            w_wdata = i_value;
        end else if (r_phase == PH_C0 || r_phase == PH_C1 ||
                     r_phase == PH_C2 || r_phase == PH_C3) begin
            w_wdata = half_sum(r_first, w_cur);
        end else if ((r_phase == PH_TOP || r_phase == PH_BOT) ? r_neg_across
                                                             : r_neg_along) begin
            w_wdata = sat_neg(w_cur);
        end else begin
            w_wdata = w_cur;
        end
        w_we = !w_off && ((r_state == S_WR) || (r_state == S_ZERO) ||
                          (in_acc && i_op == OP_WRITE));
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[{w_row[ROW_W-1:0], w_col[COL_W-1:0]}] <= w_wdata;
        end
        r_rdata  <= mem[{w_row[ROW_W-1:0], w_col[COL_W-1:0]}];
        r_rd_off <= w_off;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_TOP;
            r_a_col     <= 6'd2;
            r_a_row     <= 6'd2;
            r_b_col     <= 6'd2;
            r_b_row     <= 6'd2;
            r_thick     <= 6'd0;
            r_mode      <= 2'd0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_END_A_COL:   r_a_col <= i_cfg_data;
                    REG_END_A_ROW:   r_a_row <= i_cfg_data;
                    REG_END_B_COL:   r_b_col <= i_cfg_data;
                    REG_END_B_ROW:   r_b_row <= i_cfg_data;
                    REG_THICKNESS:   r_thick <= i_cfg_data;
                    REG_BORDER_MODE: r_mode  <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_op == OP_READ) begin
                            r_state <= S_READ;
                        end else if (i_op == OP_APPLY) begin
                            o_read_value <= '0;
                            if (g_ok) begin
                                r_xdir       <= g_xdir;
                                r_ua         <= {1'b0, g_ua};
                                r_ub         <= {1'b0, g_ub};
                                r_vb         <= {1'b0, g_vb};
                                r_vt         <= g_vt;
                                r_u          <= {1'b0, g_ua};
                                r_neg_across <= g_xdir ? (r_mode == MODE_NEG_Y)
                                                       : (r_mode == MODE_NEG_X);
                                r_neg_along  <= g_xdir ? (r_mode == MODE_NEG_X)
                                                       : (r_mode == MODE_NEG_Y);
                                r_phase      <= PH_TOP;
                                r_state      <= S_RD;
                            end else begin
                                o_status    <= STATUS_BAD;
                                o_out_valid <= 1'b1;
                                r_state     <= S_OUT;
                            end
                        end
                    end
                end
                S_READ: begin
                    o_read_value <= w_cur;
                    o_status     <= STATUS_OK;
                    o_out_valid  <= 1'b1;
                    r_state      <= S_OUT;
                end
                S_RD: begin
                    if (r_phase == PH_C0 || r_phase == PH_C1 ||
                        r_phase == PH_C2 || r_phase == PH_C3) begin
                        r_state <= S_RD2;
                    end else begin
                        r_state <= S_WR;
                    end
                end
                S_RD2: begin
                    r_first <= w_cur;
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_state <= S_RD;
                    case (r_phase)
                        PH_TOP: begin
                            r_v     <= r_vb;
                            r_state <= S_ZERO;
                        end
                        PH_BOT: begin
                            if (r_u == r_ub) begin
                                r_v     <= r_vb;
                                r_phase <= PH_SA;
                            end else begin
                                r_u     <= r_u + 7'd1;
                                r_phase <= PH_TOP;
                            end
                        end
                        PH_SA: r_phase <= PH_SB;
                        PH_SB: begin
                            if (r_v == r_vt) begin
                                r_phase <= PH_C0;
                            end else begin
                                r_v     <= r_v + 7'd1;
                                r_phase <= PH_SA;
                            end
                        end
                        PH_C0: r_phase <= PH_C1;
                        PH_C1: r_phase <= PH_C2;
                        PH_C2: r_phase <= PH_C3;
                        default: begin
                            o_status    <= STATUS_OK;
                            o_out_valid <= 1'b1;
                            r_state     <= S_OUT;
                        end
                    endcase
                end
                S_ZERO: begin
                    if (r_v == r_vt) begin
                        r_phase <= PH_BOT;
                        r_state <= S_RD;
                    end else begin
                        r_v <= r_v + 7'd1;
                    end
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        o_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[design/gobu_checker.sv]
// ---------------------------------------------------------------------------
// gobu_port_checks: port-level checks for the obstacle boundary block
// Watches request and result traffic on the top level's ports.
// ---------------------------------------------------------------------------
module gobu_port_checks
    import gobu_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_stall,
    input logic [1:0]               i_op,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic signed [DATA_W-1:0] o_read_value,
    input logic                     o_status
);

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_read_value)
                                          && $stable(o_status)))
        else $error("stalled result changed");

    // Only one request is in flight: no result while taking a new request.
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !o_out_valid)
        else $error("result pending while idle");

    // A rejected pass reports a zero value.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (o_read_value == '0))
        else $error("rejected pass with nonzero value");

    // A cell write gives no result and frees the block at once.
    a_write_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_op == OP_WRITE) |=> (!o_in_stall && !o_out_valid))
        else $error("write request held the block");

endmodule

bind grid_obstacle_boundary_update gobu_port_checks u_gobu_port_checks (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_op         (i_op),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_read_value (o_read_value),
    .o_status     (o_status)
);

[dv/gobu_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gobu_checker: response checker for the obstacle boundary block
// Watches the config port and the request and response channels, keeps its own copy of
// the grid and registers, predicts each response and compares it in order.
// ---------------------------------------------------------------------------
module gobu_checker
    import gobu_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  logic [1:0]               i_op,
    input  logic [5:0]               i_col,
    input  logic [5:0]               i_row,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  logic signed [DATA_W-1:0] i_read_value,
    input  logic                     i_status,
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_reads_checked,
    output int                       o_passes_done,
    output int                       o_passes_rejected
);

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic                     status;
    } t_response;

    logic signed [DATA_W-1:0] grid_copy [0:DEPTH-1];
    int          seg_a_col, seg_a_row, seg_b_col, seg_b_row, seg_thick;
    logic [1:0]  mode;
    t_response   awaited [$];

    function automatic logic signed [DATA_W-1:0] peek(input int c, input int r);
        if (c < 0 || r < 0 || c >= GRID_W || r >= GRID_H) begin
            return '0;
        end
        return grid_copy[r * GRID_W + c];
    endfunction

    task automatic poke(input int c, input int r, input logic signed [DATA_W-1:0] v);
        if (c >= 0 && r >= 0 && c < GRID_W && r < GRID_H) begin
            grid_copy[r * GRID_W + c] = v;
        end
    endtask

    // Value for a face cell: the cell further out, negated with saturation when flip is set.
    function automatic logic signed [DATA_W-1:0] reflect(input int c, input int r,
                                                         input bit flip);
        logic signed [DATA_W-1:0] v;
        v = peek(c, r);
        if (!flip) begin
            return v;
        end
        if (v == 32'sh8000_0000) begin
            return 32'sh7fff_ffff;
        end
        return -v;
    endfunction

    task automatic average_corner(input int c, input int r, input int c1, input int r1,
                                  input int c2, input int r2);
        longint sum;
        sum = longint'(peek(c1, r1)) + longint'(peek(c2, r2));
        poke(c, r, DATA_W'(sum >>> 1));
    endtask

    function automatic bit coord_ok(input int v, input int size);
        return v >= 2 && v <= size - 2;
    endfunction

    // Runs the boundary pass on the grid copy; returns the status bit.
    task automatic boundary_pass(output logic rejected);
        int  a0, a1, b0, b1, t, len;
        bit  along_row, flip_x, flip_y;
        a0 = seg_a_col; a1 = seg_a_row; b0 = seg_b_col; b1 = seg_b_row;
        len = seg_thick;
        flip_x = (mode == MODE_NEG_X);
        flip_y = (mode == MODE_NEG_Y);
        rejected = STATUS_BAD;
        if (!coord_ok(a0, GRID_W) || !coord_ok(b0, GRID_W) ||
            !coord_ok(a1, GRID_H) || !coord_ok(b1, GRID_H) || (a0 != b0 && a1 != b1)) begin
            return;
        end
        along_row = (a1 == b1);
        if (along_row ? (a0 > b0) : (a1 > b1)) begin
            t = a0; a0 = b0; b0 = t;
            t = a1; a1 = b1; b1 = t;
        end
        if (along_row ? !(b1 + len < GRID_H - 2) : !(b0 + len < GRID_W - 2)) begin
            return;
        end
        rejected = STATUS_OK;
        if (along_row) begin
            for (int i = a0; i <= b0; i++) begin
                poke(i, a1 + len + 1, reflect(i, a1 + len + 2, flip_y));
                for (int j = a1; j <= a1 + len; j++) poke(i, j, '0);
                poke(i, a1 - 1, reflect(i, a1 - 2, flip_y));
            end
            for (int i = a1; i <= a1 + len; i++) begin
                poke(a0 - 1, i, reflect(a0 - 2, i, flip_x));
                poke(b0 + 1, i, reflect(b0 + 2, i, flip_x));
            end
            average_corner(a0 - 1, a1 + len + 1, a0 - 1, a1 + len, a0, a1 + len + 1);
            average_corner(a0 - 1, a1 - 1, a0 - 1, a1, a0, a1 - 1);
            average_corner(b0 + 1, b1 + len + 1, b0 + 1, b1 + len, b0, b1 + len + 1);
            average_corner(b0 + 1, b1 - 1, b0 + 1, b1, b0, b1 - 1);
        end else begin
            for (int i = a1; i <= b1; i++) begin
                poke(a0 + len + 1, i, reflect(a0 + len + 2, i, flip_x));
                for (int j = a0; j <= a0 + len; j++) poke(j, i, '0);
                poke(a0 - 1, i, reflect(a0 - 2, i, flip_x));
            end
            for (int i = a0; i <= a0 + len; i++) begin
                poke(i, a1 - 1, reflect(i, a1 - 2, flip_y));
                poke(i, b1 + 1, reflect(i, b1 + 2, flip_y));
            end
            average_corner(a0 + len + 1, a1 - 1, a0 + len, a1 - 1, a0 + len + 1, a1);
            average_corner(a0 - 1, a1 - 1, a0, a1 - 1, a0 - 1, a1);
            average_corner(b0 + len + 1, b1 + 1, b0 + len, b1 + 1, b0 + len + 1, b1);
            average_corner(b0 - 1, b1 + 1, b0, b1 + 1, b0 - 1, b1);
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_reads_checked = 0;
        o_passes_done = 0;
        o_passes_rejected = 0;
        for (int k = 0; k < DEPTH; k++) grid_copy[k] = '0;
    end

    assign o_pending = awaited.size();

    always @(posedge i_clk) begin
        t_response want, got;
        logic      st;
        if (!i_rst_n) begin
            seg_a_col = 2; seg_a_row = 2; seg_b_col = 2; seg_b_row = 2;
            seg_thick = 0;
            mode = '0;
            awaited.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_END_A_COL:   seg_a_col = i_cfg_data;
                    REG_END_A_ROW:   seg_a_row = i_cfg_data;
                    REG_END_B_COL:   seg_b_col = i_cfg_data;
                    REG_END_B_ROW:   seg_b_row = i_cfg_data;
                    REG_THICKNESS:   seg_thick = i_cfg_data;
                    REG_BORDER_MODE: mode = i_cfg_data[1:0];
                    default: ;
                endcase
            end
            // The response leaves before the next request is predicted, so
            // the compare sees the queue as it stood before this edge.
            if (i_out_valid && !i_out_stall) begin
                got.read_value = i_read_value;
                got.status = i_status;
                if (awaited.size() == 0) begin
                    $error("unexpected response: read_value %0h status %0d",
                           i_read_value, i_status);
                    o_fail_count++;
                end else begin
                    want = awaited.pop_front();
                    if (got.read_value !== want.read_value) begin
                        $error("read_value: expected %0h, actual %0h",
                               want.read_value, got.read_value);
                        o_fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_op)
                    OP_WRITE: poke(i_col, i_row, i_value);
                    OP_READ: begin
                        want.read_value = peek(i_col, i_row);
                        want.status = STATUS_OK;
                        awaited.push_back(want);
                        o_reads_checked++;
                    end
                    OP_APPLY: begin
                        boundary_pass(st);
                        want.read_value = '0;
                        want.status = st;
                        awaited.push_back(want);
                        if (st == STATUS_OK) o_passes_done++;
                        else o_passes_rejected++;
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: stimulus and verdict for grid_obstacle_boundary_update
// Fills the low rows of the grid, runs directed corner cases, then random
// phases of cell requests and boundary passes under many obstacle settings;
// a checker module predicts and compares every response.
// ---------------------------------------------------------------------------
module testbench;
    import gobu_pkg::*;

    // Request code the block ignores; it must produce no response.
    localparam logic [1:0] OP_IDLE_CODE = 2'd3;

    // Only rows below this are written and read; every pass stays inside.
    localparam int WIN_ROWS = 16;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_W-1:0]         i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [1:0]               i_op = OP_WRITE;
    logic [5:0]               i_col = '0;
    logic [5:0]               i_row = '0;
    logic signed [DATA_W-1:0] i_value = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [DATA_W-1:0] o_read_value;
    logic                     o_status;

    int fail_count, pending, reads_checked, passes_done, passes_rejected;

    // Idle controls: the largest gap the sender and the receiver draw per
    // request, and a one-shot request for a long receiver hold-off.
    int gap_max = 0;
    int stall_max = 0;
    int stall_left = 0;
    bit long_hold = 1'b0;

    always #6 i_clk = ~i_clk;

    grid_obstacle_boundary_update dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_op(i_op), .i_col(i_col), .i_row(i_row), .i_value(i_value),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_read_value(o_read_value), .o_status(o_status)
    );

    gobu_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_op(i_op), .i_col(i_col), .i_row(i_row), .i_value(i_value),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_read_value(o_read_value), .i_status(o_status),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_reads_checked(reads_checked), .o_passes_done(passes_done),
        .o_passes_rejected(passes_rejected)
    );

    // Receiver: after each accepted response it draws a new stall length.
    // A long hold-off is counted down here while the sender keeps going.
    always @(negedge i_clk) begin
        if (long_hold) begin
            long_hold = 1'b0;
            stall_left = 400;
        end
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall) begin
            stall_left = $urandom_range(0, stall_max);
        end
    end

    // Safety net far beyond the slowest legal run.
    initial begin
        #200_000_000;
        $display("Verification failed");
        $finish;
    end

    // Presents one request after a random gap and holds it until taken.
    // The task starts and ends at a falling edge.
    task automatic send_request(input logic [1:0] op, input int c,
                                input int r, input logic [31:0] v);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_col <= 6'(c);
        i_row <= 6'(r);
        i_value <= v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Waits until every response is in, then lets a trailing write drain.
    task automatic drain_block();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_W'(val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_obstacle(input int ac, input int ar, input int bc, input int br,
                                input int thick, input int mode);
        drain_block();
        write_reg(REG_END_A_COL, ac);
        write_reg(REG_END_A_ROW, ar);
        write_reg(REG_END_B_COL, bc);
        write_reg(REG_END_B_ROW, br);
        write_reg(REG_THICKNESS, thick);
        write_reg(REG_BORDER_MODE, mode);
    endtask

    function automatic logic [31:0] cell_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    // True when the geometry is rejected, or when every cell its pass
    // touches lies in the written rows.
    function automatic bit in_window(input int ac, input int ar, input int bc, input int br,
                                     input int thick);
        if (ac < 2 || ac > 62 || bc < 2 || bc > 62 || ar < 2 || ar > 62 ||
            br < 2 || br > 62 || (ac != bc && ar != br)) begin
            return 1'b1;
        end
        if (ar == br) begin
            return (ar + thick >= 62) || (ar + thick + 2 < WIN_ROWS);
        end
        if (ac + thick >= 62) begin
            return 1'b1;
        end
        return ((ar > br) ? ar : br) + 2 < WIN_ROWS;
    endfunction

    // Mostly legal obstacles with small thickness; some large ones and some
    // geometry drawn at random, which the block is likely to reject.
    task automatic random_obstacle();
        int thick, lane, p, q, ac, ar, bc, br;
        if ($urandom_range(0, 4) == 0) begin
            do begin
                ac = $urandom_range(0, 63);
                ar = $urandom_range(0, 63);
                bc = $urandom_range(0, 63);
                br = $urandom_range(0, 63);
                thick = $urandom_range(0, 63);
            end while (!in_window(ac, ar, bc, br, thick));
            set_obstacle(ac, ar, bc, br, thick, $urandom_range(0, 3));
            return;
        end
        thick = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 59) : $urandom_range(0, 4);
        if (thick <= 4 && $urandom_range(0, 1)) begin
            // Row segment: the obstacle and both faces fit in the written rows.
            lane = $urandom_range(2, WIN_ROWS - 3 - thick);
            p = $urandom_range(2, 62);
            q = ($urandom_range(0, 7) == 0) ? p : $urandom_range(2, 62);
            set_obstacle(p, lane, q, lane, thick, $urandom_range(0, 3));
        end else begin
            lane = $urandom_range(2, 61 - thick);
            p = $urandom_range(2, WIN_ROWS - 3);
            q = ($urandom_range(0, 7) == 0) ? p : $urandom_range(2, WIN_ROWS - 3);
            set_obstacle(lane, p, lane, q, thick, $urandom_range(0, 3));
        end
    endtask

    initial begin
        int taken;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Every cell of the low rows is written once up front; all later
        // reads and passes stay inside these rows.
        for (int r = 0; r < WIN_ROWS; r++) begin
            for (int c = 0; c < GRID_W; c++) begin
                send_request(OP_WRITE, c, r, cell_value());
            end
        end

        // Directed part with idling on both sides.
        gap_max = 3;
        stall_max = 3;
        send_request(OP_READ, 0, 0, '0);
        send_request(OP_READ, 63, WIN_ROWS - 1, '0);
        send_request(OP_WRITE, 63, 0, 32'h8000_0000);
        send_request(OP_READ, 63, 0, 32'hffff_ffff);
        send_request(OP_APPLY, 0, 0, '0);           // reset obstacle: one cell
        send_request(OP_IDLE_CODE, 5, 5, 32'h1234_5678);
        send_request(OP_READ, 2, 3, '0);
        // Most negative value beyond a y face, negated with saturation.
        set_obstacle(10, 8, 5, 8, 1, MODE_NEG_Y);
        send_request(OP_WRITE, 7, 11, 32'h8000_0000);
        send_request(OP_WRITE, 8, 6, 32'h7fff_ffff);
        send_request(OP_APPLY, 0, 0, '0);
        send_request(OP_READ, 7, 10, '0);
        send_request(OP_READ, 8, 7, '0);
        send_request(OP_READ, 4, 10, '0);
        // Column segment at the far edge, negation across x faces.
        set_obstacle(60, 13, 60, 2, 1, MODE_NEG_X);
        send_request(OP_WRITE, 63, 10, 32'h8000_0000);
        send_request(OP_APPLY, 0, 0, '0);
        send_request(OP_READ, 62, 10, '0);
        set_obstacle(2, 10, 62, 10, 0, 3);          // unused mode copies
        send_request(OP_APPLY, 0, 0, '0);
        // Rejected geometry: coordinate too low, too high, not aligned, and
        // thickness reaching the border.
        set_obstacle(1, 10, 5, 10, 0, 0);
        send_request(OP_APPLY, 0, 0, '0);
        set_obstacle(63, 10, 5, 10, 0, 0);
        send_request(OP_APPLY, 0, 0, '0);
        set_obstacle(4, 10, 5, 11, 0, 0);
        send_request(OP_APPLY, 0, 0, '0);
        set_obstacle(4, 10, 5, 10, 52, 0);
        send_request(OP_APPLY, 0, 0, '0);
        set_obstacle(30, 4, 30, 9, 63, 1);
        send_request(OP_APPLY, 0, 0, '0);

        // Random phases; some run without idling, one has the long hold-off
        // with reads held back behind it.
        taken = 0;
        for (int phase = 0; taken < 450; phase++) begin
            random_obstacle();
            gap_max = (phase % 5 == 1) ? 0 : 15;
            stall_max = (phase % 5 == 1) ? 0 : 15;
            if (phase == 3) begin
                long_hold = 1'b1;
                for (int k = 0; k < 40; k++) begin
                    send_request(OP_READ, $urandom_range(0, 63),
                                 $urandom_range(0, WIN_ROWS - 1), $urandom);
                    taken++;
                end
            end
            for (int k = 0; k < 50; k++) begin
                case ($urandom_range(0, 19))
                    0:      send_request(OP_IDLE_CODE, $urandom_range(0, 63),
                                         $urandom_range(0, 63), $urandom);
                    1, 2:   begin
                                send_request(OP_APPLY, $urandom_range(0, 63),
                                             $urandom_range(0, 63), $urandom);
                                taken++;
                            end
                    3, 4, 5, 6, 7, 8, 9, 10:
                            begin
                                send_request(OP_READ, $urandom_range(0, 63),
                                             $urandom_range(0, WIN_ROWS - 1), $urandom);
                                taken++;
                            end
                    default:
                            begin
                                send_request(OP_WRITE, $urandom_range(0, 63),
                                             $urandom_range(0, WIN_ROWS - 1), cell_value());
                                taken++;
                            end
                endcase
            end
        end

        drain_block();
        $display("Checked %0d cell reads and %0d boundary passes (%0d rejected).",
                 reads_checked, passes_done + passes_rejected, passes_rejected);
        $display("Obstacle settings covered row and column segments, all border modes.");
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
